// File: design/cube_map_texel_address_top_macros.svh
// assertion macros used by the top-level design file
`ifndef CUBE_MAP_TEXEL_ADDRESS_TOP_MACROS_SVH
`define CUBE_MAP_TEXEL_ADDRESS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CMTA_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CMTA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CMTA_ASSERT_RST(name, prop, msg)

`define CMTA_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: design/cmta_pkg.sv
package cmta_pkg;

  localparam int unsigned DirW        = 16;
  localparam int unsigned SizeW       = 12;
  localparam int unsigned IdxW        = 11;
  localparam int unsigned FracW       = 8;
  localparam int unsigned MaxFaceSize = 2048;
  localparam logic [SizeW-1:0] FaceSizeReset = SizeW'(256);

  // magnitude of a component, up to 2^(DirW-1)
  localparam int unsigned MagW = DirW;
  // minor component plus major magnitude, 0 .. 2*ama
  localparam int unsigned OffW = DirW + 1;
  // divisor 2*ama
  localparam int unsigned DenW = MagW + 1;
  // offset times face size
  localparam int unsigned NumW = OffW + SizeW;
  // quotient: index bits, one spare for the clamp case, fraction bits
  localparam int unsigned QuoW = IdxW + FracW + 1;

  typedef enum logic [1:0] {
    AxisX,
    AxisY,
    AxisZ
  } axis_e;

  typedef enum logic [2:0] {
    FacePosX,
    FaceNegX,
    FacePosY,
    FaceNegY,
    FacePosZ,
    FaceNegZ
  } face_e;

  typedef struct packed {
    face_e face;
    logic  zero;
  } tag_t;

  typedef struct packed {
    logic [OffW-1:0] off_s;
    logic [OffW-1:0] off_t;
    logic [MagW-1:0] ama;
    tag_t            tag;
  } coord_t;

  typedef struct packed {
    logic [NumW-1:0] num_s;
    logic [NumW-1:0] num_t;
    logic [DenW-1:0] den;
    tag_t            tag;
  } quot_in_t;

  typedef struct packed {
    logic [QuoW-1:0] q_s;
    logic [QuoW-1:0] q_t;
    tag_t            tag;
  } quot_out_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] raw);
    logic [SizeW-1:0] r;
    if (raw == '0) begin
      r = SizeW'(1);
    end else if (raw > SizeW'(MaxFaceSize)) begin
      r = SizeW'(MaxFaceSize);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage

// File: design/cmta_face_sel.sv
module cmta_face_sel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [cmta_pkg::DirW-1:0]         dir_x_i,
  input  logic [cmta_pkg::DirW-1:0]         dir_y_i,
  input  logic [cmta_pkg::DirW-1:0]         dir_z_i,
  output logic                              valid_o,
  output cmta_pkg::coord_t                  coord_o
);

  function automatic logic [cmta_pkg::MagW-1:0] magn(logic [cmta_pkg::DirW-1:0] v);
    logic [cmta_pkg::DirW-1:0] n;
    n = ~v + cmta_pkg::DirW'(1);
    return v[cmta_pkg::DirW-1] ? cmta_pkg::MagW'(n) : cmta_pkg::MagW'(v);
  endfunction

  // gl axes: x <- dir_y, y <- dir_z, z <- dir_x
  logic [cmta_pkg::DirW-1:0] g [3];
  assign g[0] = dir_y_i;
  assign g[1] = dir_z_i;
  assign g[2] = dir_x_i;

  // stage a: magnitudes and major axis
  logic [cmta_pkg::MagW-1:0] a0, a1, a2;
  logic [cmta_pkg::MagW-1:0] ama_d;
  cmta_pkg::axis_e           axis_d;
  logic                      neg_d;
  logic                      zero_d;

  always_comb begin
    a0 = magn(g[0]);
    a1 = magn(g[1]);
    a2 = magn(g[2]);
    axis_d = cmta_pkg::AxisX;
    ama_d  = a0;
    neg_d  = g[0][cmta_pkg::DirW-1];
    if (a1 > a0) begin
      axis_d = cmta_pkg::AxisY;
      ama_d  = a1;
      neg_d  = g[1][cmta_pkg::DirW-1];
    end
    if (a2 > ama_d) begin
      axis_d = cmta_pkg::AxisZ;
      ama_d  = a2;
      neg_d  = g[2][cmta_pkg::DirW-1];
    end
    zero_d = (a0 == '0) && (a1 == '0) && (a2 == '0);
  end

  logic                      vld_a_q;
  logic [cmta_pkg::DirW-1:0] g_a_q [3];
  logic [cmta_pkg::MagW-1:0] ama_a_q;
  cmta_pkg::axis_e           axis_a_q;
  logic                      neg_a_q;
  logic                      zero_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    g_a_q    <= g;
    ama_a_q  <= ama_d;
    axis_a_q <= axis_d;
    neg_a_q  <= neg_d;
    zero_a_q <= zero_d;
  end

  // stage b: face, minor components, offsets
  logic [cmta_pkg::OffW-1:0] e0, e1, e2;
  logic [cmta_pkg::OffW-1:0] sc, tc;
  cmta_pkg::face_e           face_d;
  cmta_pkg::coord_t          coord_d;

  always_comb begin
    e0 = {g_a_q[0][cmta_pkg::DirW-1], g_a_q[0]};
    e1 = {g_a_q[1][cmta_pkg::DirW-1], g_a_q[1]};
    e2 = {g_a_q[2][cmta_pkg::DirW-1], g_a_q[2]};
    unique case (axis_a_q)
      cmta_pkg::AxisX: face_d = neg_a_q ? cmta_pkg::FaceNegX : cmta_pkg::FacePosX;
      cmta_pkg::AxisY: face_d = neg_a_q ? cmta_pkg::FaceNegY : cmta_pkg::FacePosY;
      cmta_pkg::AxisZ: face_d = neg_a_q ? cmta_pkg::FaceNegZ : cmta_pkg::FacePosZ;
      default:         face_d = cmta_pkg::FacePosX;
    endcase
    unique case (face_d)
      cmta_pkg::FacePosX: begin
        sc = '0 - e2;
        tc = '0 - e1;
      end
      cmta_pkg::FaceNegX: begin
        sc = e2;
        tc = '0 - e1;
      end
      cmta_pkg::FacePosY: begin
        sc = e0;
        tc = e2;
      end
      cmta_pkg::FaceNegY: begin
        sc = e0;
        tc = '0 - e2;
      end
      cmta_pkg::FacePosZ: begin
        sc = e0;
        tc = '0 - e1;
      end
      cmta_pkg::FaceNegZ: begin
        sc = '0 - e0;
        tc = '0 - e1;
      end
      default: begin
        sc = '0;
        tc = '0;
      end
    endcase
    coord_d.off_s    = sc + cmta_pkg::OffW'(ama_a_q);
    coord_d.off_t    = tc + cmta_pkg::OffW'(ama_a_q);
    coord_d.ama      = ama_a_q;
    coord_d.tag.face = face_d;
    coord_d.tag.zero = zero_a_q;
  end

  logic             vld_b_q;
  cmta_pkg::coord_t coord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
  end

  assign valid_o = vld_b_q;
  assign coord_o = coord_q;

endmodule

// File: design/cmta_scale.sv
module cmta_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  cmta_pkg::coord_t           coord_i,
  input  logic [cmta_pkg::SizeW-1:0] size_i,
  output logic                       valid_o,
  output cmta_pkg::quot_in_t         op_o
);

  cmta_pkg::quot_in_t op_d;
  cmta_pkg::quot_in_t op_q;
  logic               vld_q;

  // offset times face size, divisor 2*ama
  always_comb begin
    op_d.num_s = cmta_pkg::NumW'(coord_i.off_s) * cmta_pkg::NumW'(size_i);
    op_d.num_t = cmta_pkg::NumW'(coord_i.off_t) * cmta_pkg::NumW'(size_i);
    op_d.den   = {coord_i.ama, 1'b0};
    op_d.tag   = coord_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = vld_q;
  assign op_o    = op_q;

endmodule

// File: design/cmta_div.sv
module cmta_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cmta_pkg::quot_in_t  op_i,
  output logic                valid_o,
  output cmta_pkg::quot_out_t res_o
);

  localparam int unsigned Steps = cmta_pkg::QuoW;
  localparam int unsigned LowW  = cmta_pkg::QuoW - cmta_pkg::FracW;

  // qd holds the dividend bits still to come and shifts quotient bits in
  typedef struct packed {
    logic [cmta_pkg::DenW-1:0] rem_s;
    logic [cmta_pkg::QuoW-1:0] qd_s;
    logic [cmta_pkg::DenW-1:0] rem_t;
    logic [cmta_pkg::QuoW-1:0] qd_t;
    logic [cmta_pkg::DenW-1:0] den;
    cmta_pkg::tag_t            tag;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    logic [cmta_pkg::DenW:0] ts;
    logic [cmta_pkg::DenW:0] tt;
    logic [cmta_pkg::DenW:0] dd;
    logic                    ges;
    logic                    get;
    div_st_t                 r;
    r   = s;
    dd  = {1'b0, s.den};
    ts  = {s.rem_s, s.qd_s[cmta_pkg::QuoW-1]};
    tt  = {s.rem_t, s.qd_t[cmta_pkg::QuoW-1]};
    ges = ts >= dd;
    get = tt >= dd;
    r.rem_s = ges ? cmta_pkg::DenW'(ts - dd) : cmta_pkg::DenW'(ts);
    r.rem_t = get ? cmta_pkg::DenW'(tt - dd) : cmta_pkg::DenW'(tt);
    r.qd_s  = {s.qd_s[cmta_pkg::QuoW-2:0], ges};
    r.qd_t  = {s.qd_t[cmta_pkg::QuoW-2:0], get};
    return r;
  endfunction

  // upper dividend bits are already below the divisor
  div_st_t init;
  always_comb begin
    init.rem_s = op_i.num_s[cmta_pkg::NumW-1 -: cmta_pkg::DenW];
    init.rem_t = op_i.num_t[cmta_pkg::NumW-1 -: cmta_pkg::DenW];
    init.qd_s  = {op_i.num_s[LowW-1:0], {cmta_pkg::FracW{1'b0}}};
    init.qd_t  = {op_i.num_t[LowW-1:0], {cmta_pkg::FracW{1'b0}}};
    init.den   = op_i.den;
    init.tag   = op_i.tag;
  end

  div_st_t st_q  [Steps];
  logic    vld_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    div_st_t src;
    logic    src_v;
    if (k == 0) begin : g_first
      assign src   = init;
      assign src_v = valid_i;
    end else begin : g_rest
      assign src   = st_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= div_step(src);
    end
  end

  assign valid_o   = vld_q[Steps-1];
  assign res_o.q_s = st_q[Steps-1].qd_s;
  assign res_o.q_t = st_q[Steps-1].qd_t;
  assign res_o.tag = st_q[Steps-1].tag;

endmodule

// File: design/cube_map_texel_address_top.sv
// Cube map texel addressing. A direction (dir_x_i, dir_y_i, dir_z_i, signed
// Q1.14, z-up axes) is taken at every rising edge where start is high; busy
// is never raised, so one item can enter on every clock. The result (face,
// bilinear texel indices, 8-bit fractions, zero-direction flag) is on the
// outputs for exactly one cycle with done_o high; it must be captured then:
// the block has no way to hold a result. The depth is set by the two-lane
// restoring divider, 20 stages with one quotient bit per stage, behind three
// stages of face selection and scaling and ahead of one output register.
// face_size is written through the cfg channel, which is always ready; write
// it only while no item is in flight. A size of 0 acts as 1 and sizes above
// 2048 act as 2048.
`include "cube_map_texel_address_top_macros.svh"

module cube_map_texel_address_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [cmta_pkg::DirW-1:0]  dir_x_i,
  input  logic [cmta_pkg::DirW-1:0]  dir_y_i,
  input  logic [cmta_pkg::DirW-1:0]  dir_z_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cmta_pkg::SizeW-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [2:0]                 face_o,
  output logic [cmta_pkg::IdxW-1:0]  tex_x0_o,
  output logic [cmta_pkg::IdxW-1:0]  tex_x1_o,
  output logic [cmta_pkg::IdxW-1:0]  tex_y0_o,
  output logic [cmta_pkg::IdxW-1:0]  tex_y1_o,
  output logic [cmta_pkg::FracW-1:0] frac_x_o,
  output logic [cmta_pkg::FracW-1:0] frac_y_o,
  output logic                       zero_direction_o
);

  localparam int unsigned Latency = cmta_pkg::QuoW + 4;
  localparam int unsigned TopW    = cmta_pkg::QuoW - cmta_pkg::FracW;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // face size register
  logic [cmta_pkg::SizeW-1:0] face_size_q;
  logic [cmta_pkg::SizeW-1:0] size_eff;
  logic [cmta_pkg::IdxW-1:0]  last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= cmta_pkg::FaceSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      face_size_q <= cfg_data_i;
    end
  end

  assign size_eff = cmta_pkg::clamp_size(face_size_q);
  assign last     = cmta_pkg::IdxW'(size_eff - cmta_pkg::SizeW'(1));

  logic                v_sel;
  cmta_pkg::coord_t    coord;
  logic                v_scl;
  cmta_pkg::quot_in_t  op;
  logic                v_div;
  cmta_pkg::quot_out_t res;

  cmta_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (v_sel),
    .coord_o (coord)
  );

  cmta_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_sel),
    .coord_i (coord),
    .size_i  (size_eff),
    .valid_o (v_scl),
    .op_o    (op)
  );

  cmta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_scl),
    .op_i    (op),
    .valid_o (v_div),
    .res_o   (res)
  );

  // index clamp and upper neighbor
  logic [TopW-1:0]             ix, iy;
  logic [cmta_pkg::IdxW-1:0]   x0_d, x1_d, y0_d, y1_d;
  logic [cmta_pkg::FracW-1:0]  fx_d, fy_d;
  logic [2:0]                  face_d;

  always_comb begin
    ix   = res.q_s[cmta_pkg::QuoW-1:cmta_pkg::FracW];
    iy   = res.q_t[cmta_pkg::QuoW-1:cmta_pkg::FracW];
    x0_d = (ix > TopW'(last)) ? last : cmta_pkg::IdxW'(ix);
    y0_d = (iy > TopW'(last)) ? last : cmta_pkg::IdxW'(iy);
    x1_d = (x0_d == last) ? last : x0_d + cmta_pkg::IdxW'(1);
    y1_d = (y0_d == last) ? last : y0_d + cmta_pkg::IdxW'(1);
    fx_d = res.q_s[cmta_pkg::FracW-1:0];
    fy_d = res.q_t[cmta_pkg::FracW-1:0];
    face_d = res.tag.face;
    if (res.tag.zero) begin
      x0_d   = '0;
      x1_d   = '0;
      y0_d   = '0;
      y1_d   = '0;
      fx_d   = '0;
      fy_d   = '0;
      face_d = '0;
    end
  end

  logic                       done_q;
  logic [2:0]                 face_q;
  logic [cmta_pkg::IdxW-1:0]  x0_q, x1_q, y0_q, y1_q;
  logic [cmta_pkg::FracW-1:0] fx_q, fy_q;
  logic                       zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_div;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q <= face_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y0_q   <= y0_d;
    y1_q   <= y1_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    zero_q <= res.tag.zero;
  end

  assign done_o           = done_q;
  assign face_o           = face_q;
  assign tex_x0_o         = x0_q;
  assign tex_x1_o         = x1_q;
  assign tex_y0_o         = y0_q;
  assign tex_y1_o         = y1_q;
  assign frac_x_o         = fx_q;
  assign frac_y_o         = fy_q;
  assign zero_direction_o = zero_q;

  `CMTA_ASSERT_RST(a_done_has_item, done_o |-> $past(accept, Latency), "result without an accepted item")
  `CMTA_ASSERT_RST(a_zero_clean, done_o && zero_direction_o |-> face_o == '0 && tex_x0_o == '0 && tex_x1_o == '0 && tex_y0_o == '0 && tex_y1_o == '0 && frac_x_o == '0 && frac_y_o == '0, "zero direction with nonzero fields")
  `CMTA_ASSERT_RST(a_neighbor, done_o |-> (tex_x1_o == tex_x0_o || tex_x1_o == tex_x0_o + cmta_pkg::IdxW'(1)) && (tex_y1_o == tex_y0_o || tex_y1_o == tex_y0_o + cmta_pkg::IdxW'(1)), "upper neighbor not next to lower index")
  `CMTA_ASSERT_RST(a_cfg_write, cfg_valid_i && cfg_ready_o |=> face_size_q == $past(cfg_data_i), "face size write lost")
  `CMTA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result strobe right after reset")

endmodule

// File: test/tb_cube_map_texel_address_top.sv
`timescale 1ns / 1ps

module tb_cube_map_texel_address_top;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [2:0]                 face;
    logic [cmta_pkg::IdxW-1:0]  x0;
    logic [cmta_pkg::IdxW-1:0]  x1;
    logic [cmta_pkg::IdxW-1:0]  y0;
    logic [cmta_pkg::IdxW-1:0]  y1;
    logic [cmta_pkg::FracW-1:0] fx;
    logic [cmta_pkg::FracW-1:0] fy;
    logic                       zero;
  } texel_res_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [cmta_pkg::DirW-1:0]   dir_x_i = '0;
  logic [cmta_pkg::DirW-1:0]   dir_y_i = '0;
  logic [cmta_pkg::DirW-1:0]   dir_z_i = '0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [cmta_pkg::SizeW-1:0]  cfg_data_i = '0;
  logic                        done_o;
  logic [2:0]                  face_o;
  logic [cmta_pkg::IdxW-1:0]   tex_x0_o;
  logic [cmta_pkg::IdxW-1:0]   tex_x1_o;
  logic [cmta_pkg::IdxW-1:0]   tex_y0_o;
  logic [cmta_pkg::IdxW-1:0]   tex_y1_o;
  logic [cmta_pkg::FracW-1:0]  frac_x_o;
  logic [cmta_pkg::FracW-1:0]  frac_y_o;
  logic                        zero_direction_o;

  texel_res_t                  pending_texels[$];
  logic [cmta_pkg::SizeW-1:0]  face_size_reg = cmta_pkg::FaceSizeReset;
  int                          idle_pct = 0;
  int                          items_sent = 0;
  int                          results_seen = 0;
  int                          size_writes = 0;
  int                          mismatches = 0;
  int                          quiet_cycles = 0;

  cube_map_texel_address_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .dir_x_i          (dir_x_i),
    .dir_y_i          (dir_y_i),
    .dir_z_i          (dir_z_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .face_o           (face_o),
    .tex_x0_o         (tex_x0_o),
    .tex_x1_o         (tex_x1_o),
    .tex_y0_o         (tex_y0_o),
    .tex_y1_o         (tex_y1_o),
    .frac_x_o         (frac_x_o),
    .frac_y_o         (frac_y_o),
    .zero_direction_o (zero_direction_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void map_coord(input longint c, input longint ama, input longint sz,
                                    output logic [cmta_pkg::IdxW-1:0] i0,
                                    output logic [cmta_pkg::IdxW-1:0] i1,
                                    output logic [cmta_pkg::FracW-1:0] fr);
    longint q;
    longint idx;
    longint last;
    q    = (((c + ama) * sz) << cmta_pkg::FracW) / (2 * ama);
    idx  = q >> cmta_pkg::FracW;
    last = sz - 1;
    fr   = cmta_pkg::FracW'(q);
    if (idx > last) begin
      idx = last;
    end
    i0 = cmta_pkg::IdxW'(idx);
    i1 = cmta_pkg::IdxW'((idx + 1 > last) ? last : idx + 1);
  endfunction

  function automatic texel_res_t predict_texel(logic [cmta_pkg::DirW-1:0] dx,
                                               logic [cmta_pkg::DirW-1:0] dy,
                                               logic [cmta_pkg::DirW-1:0] dz,
                                               logic [cmta_pkg::SizeW-1:0] size_raw);
    longint          g[3];
    longint          a[3];
    longint          sc;
    longint          tc;
    longint          ama;
    longint          sz;
    int              axis;
    cmta_pkg::face_e f;
    texel_res_t      r;
    r    = '0;
    g[0] = longint'($signed(dy));
    g[1] = longint'($signed(dz));
    g[2] = longint'($signed(dx));
    for (int k = 0; k < 3; k++) begin
      a[k] = (g[k] < 0) ? -g[k] : g[k];
    end
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      r.zero = 1'b1;
      return r;
    end
    axis = 0;
    if (a[1] > a[axis]) begin
      axis = 1;
    end
    if (a[2] > a[axis]) begin
      axis = 2;
    end
    ama = a[axis];
    f   = cmta_pkg::face_e'(3'(axis * 2 + ((g[axis] < 0) ? 1 : 0)));
    case (f)
      cmta_pkg::FacePosX: begin
        sc = -g[2];
        tc = -g[1];
      end
      cmta_pkg::FaceNegX: begin
        sc = g[2];
        tc = -g[1];
      end
      cmta_pkg::FacePosY: begin
        sc = g[0];
        tc = g[2];
      end
      cmta_pkg::FaceNegY: begin
        sc = g[0];
        tc = -g[2];
      end
      cmta_pkg::FacePosZ: begin
        sc = g[0];
        tc = -g[1];
      end
      default: begin
        sc = -g[0];
        tc = -g[1];
      end
    endcase
    sz = longint'(size_raw);
    if (sz == 0) begin
      sz = 1;
    end
    if (sz > cmta_pkg::MaxFaceSize) begin
      sz = cmta_pkg::MaxFaceSize;
    end
    r.face = f;
    map_coord(sc, ama, sz, r.x0, r.x1, r.fx);
    map_coord(tc, ama, sz, r.y0, r.y1, r.fy);
    return r;
  endfunction

  function automatic logic [cmta_pkg::DirW-1:0] pick_edge_value();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic void random_direction(output logic [cmta_pkg::DirW-1:0] dx,
                                           output logic [cmta_pkg::DirW-1:0] dy,
                                           output logic [cmta_pkg::DirW-1:0] dz);
    logic [cmta_pkg::DirW-1:0] c[3];
    logic [cmta_pkg::DirW-1:0] v;
    int                        major;
    int                        minor;
    v = cmta_pkg::DirW'($urandom);
    case ($urandom_range(9))
      5: begin
        for (int k = 0; k < 3; k++) c[k] = cmta_pkg::DirW'(int'($urandom_range(6)) - 3);
      end
      6: begin
        // ties in magnitude
        for (int k = 0; k < 3; k++) begin
          c[k] = ($urandom_range(3) == 0) ? cmta_pkg::DirW'($urandom_range(3)) :
                 ($urandom_range(1) ? v : -v);
        end
      end
      7: begin
        for (int k = 0; k < 3; k++) c[k] = pick_edge_value();
      end
      8: begin
        // minor component equal to the major magnitude, coordinate at one
        for (int k = 0; k < 3; k++) c[k] = cmta_pkg::DirW'($urandom_range(255)) - 16'd128;
        if (v == 16'h8000) v = 16'h7fff;
        major    = $urandom_range(2);
        minor    = (major + 1 + $urandom_range(1)) % 3;
        c[major] = $urandom_range(1) ? v : -v;
        c[minor] = $urandom_range(1) ? v : -v;
      end
      default: begin
        for (int k = 0; k < 3; k++) c[k] = cmta_pkg::DirW'($urandom);
      end
    endcase
    dx = c[0];
    dy = c[1];
    dz = c[2];
  endfunction

  task automatic send_direction(input logic [cmta_pkg::DirW-1:0] dx,
                                input logic [cmta_pkg::DirW-1:0] dy,
                                input logic [cmta_pkg::DirW-1:0] dz);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    dir_x_i = dx;
    dir_y_i = dy;
    dir_z_i = dz;
    start   = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_texels.push_back(predict_texel(dx, dy, dz, face_size_reg));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_directions(input int count);
    logic [cmta_pkg::DirW-1:0] dx;
    logic [cmta_pkg::DirW-1:0] dy;
    logic [cmta_pkg::DirW-1:0] dz;
    repeat (count) begin
      random_direction(dx, dy, dz);
      send_direction(dx, dy, dz);
    end
  endtask

  task automatic write_face_size(input logic [cmta_pkg::SizeW-1:0] value);
    start = 1'b0;
    while (pending_texels.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    face_size_reg = value;
    size_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_direction(16'sd0, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sd16384, 16'sd0);
    send_direction(16'sd0, -16'sd16384, 16'sd0);
    send_direction(16'sd0, 16'sd0, 16'sd16384);
    send_direction(16'sd0, 16'sd0, -16'sd16384);
    send_direction(16'sd16384, 16'sd0, 16'sd0);
    send_direction(-16'sd16384, 16'sd0, 16'sd0);
    send_direction(16'sd32767, 16'sd32767, 16'sd32767);
    send_direction(16'h8000, 16'h8000, 16'h8000);
    send_direction(16'h8000, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'h8000, 16'sd0);
    send_direction(16'sd0, 16'sd0, 16'h8000);
    send_direction(16'sd32767, 16'h8000, 16'sd1);
    send_direction(-16'sd100, 16'sd100, 16'sd0);
    send_direction(16'sd0, 16'sd100, -16'sd100);
    send_direction(-16'sd100, 16'sd100, -16'sd100);
    send_direction(16'sd0, 16'sd5, -16'sd5);
    send_direction(16'sd7, 16'sd0, 16'sd7);
    send_direction(-16'sd9, -16'sd9, 16'sd9);
    send_direction(16'sd1, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sd0, -16'sd1);
    send_direction(-16'sd1, 16'sd1, -16'sd1);
    send_direction(16'sd32767, -16'sd1, 16'sd1);
    send_direction(16'h1234, 16'hfedc, 16'h5a5a);
  endtask

  task automatic test_face_sizes();
    logic [cmta_pkg::SizeW-1:0] sizes[8];
    sizes = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd2049, 12'd2, 12'd1000, 12'd0};
    sizes[7] = cmta_pkg::SizeW'($urandom_range(1, 2047));
    for (int i = 0; i < 8; i++) begin
      idle_pct = (i % 2 == 0) ? 0 : 18;
      write_face_size(sizes[i]);
      send_random_directions(25);
    end
  endtask

  task automatic test_random_traffic();
    int pcts[3];
    pcts = '{0, 55, 18};
    for (int i = 0; i < 3; i++) begin
      idle_pct = pcts[i];
      write_face_size(cmta_pkg::SizeW'($urandom));
      send_random_directions(90);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    texel_res_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_texels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result at %0t: face %0d x %0d/%0d y %0d/%0d", $realtime,
                   face_o, tex_x0_o, tex_x1_o, tex_y0_o, tex_y1_o);
        end
      end else begin
        want = pending_texels.pop_front();
        if (want.face !== face_o || want.x0 !== tex_x0_o || want.x1 !== tex_x1_o ||
            want.y0 !== tex_y0_o || want.y1 !== tex_y1_o || want.fx !== frac_x_o ||
            want.fy !== frac_y_o || want.zero !== zero_direction_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected face %0d x %0d/%0d y %0d/%0d frac %0d/%0d zero %0b",
                     want.face, want.x0, want.x1, want.y0, want.y1, want.fx, want.fy,
                     want.zero);
            $display("  actual   face %0d x %0d/%0d y %0d/%0d frac %0d/%0d zero %0b",
                     face_o, tex_x0_o, tex_x1_o, tex_y0_o, tex_y1_o, frac_x_o, frac_y_o,
                     zero_direction_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_face_sizes();
    test_random_traffic();
    start = 1'b0;
    while (pending_texels.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("sent %0d directions across %0d face size writes, checked %0d results",
             items_sent, size_writes, results_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
